// ----- rtl/segment_page_run_allocator_core_assert.svh -----
// Assertion macros used by the allocator checker
`ifndef SEGMENT_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define SEGMENT_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SPRA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spra assertion failed");

// next-cycle implication
`define SPRA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spra assertion failed");

`endif

// ----- rtl/spra_pkg.sv -----
// Shared types, constants and helpers of the segment page-run allocator
package spra_pkg;

	localparam int NUM_SEGMENTS_DEF = 1024;
	localparam int MAX_HOPS_DEF     = 8;
	localparam int PAGES_PER_SEG    = 32;
	localparam int PAGE_W           = 15;
	localparam int RUN_W            = 6;
	localparam int MASK_W           = PAGES_PER_SEG;
	localparam int OFS_W            = $clog2(PAGES_PER_SEG);

	localparam logic [MASK_W-1:0] SEG_FULL = '1;

	localparam logic REQ_TAKE    = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic STAT_OK        = 1'b0;
	localparam logic STAT_EXHAUSTED = 1'b1;

	typedef struct packed {
		logic             found;
		logic [OFS_W-1:0] start;
	} fit_t;

	function automatic logic [RUN_W-1:0] sat_pages(input logic [RUN_W-1:0] n);
		logic [RUN_W-1:0] r;
		r = n;
		if (n == '0) r = RUN_W'(1);
		if (n > RUN_W'(PAGES_PER_SEG)) r = RUN_W'(PAGES_PER_SEG);
		return r;
	endfunction

	function automatic logic [MASK_W-1:0] run_bits(input logic [RUN_W-1:0] n);
		logic [MASK_W:0] t;
		t = ({{MASK_W{1'b0}}, 1'b1} << n) - 1'b1;
		return (n >= RUN_W'(PAGES_PER_SEG)) ? SEG_FULL : t[MASK_W-1:0];
	endfunction

endpackage

// ----- rtl/spra_if.sv -----
// Valid/ready channel interfaces for request and response words
interface spra_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [spra_pkg::RUN_W-1:0]  run_pages;
	logic [spra_pkg::PAGE_W-1:0] page_index;

	modport source (output valid, req_type, run_pages, page_index, input ready);
	modport sink (input valid, req_type, run_pages, page_index, output ready);
endinterface

interface spra_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [spra_pkg::PAGE_W-1:0] page_index_out;
	logic                        status;

	modport source (output valid, page_index_out, status, input ready);
	modport sink (input valid, page_index_out, status, output ready);
endinterface

// ----- rtl/spra_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module spra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ----- rtl/spra_run_find.sv -----
// Finds the lowest-starting run of free pages in a segment mask
module spra_run_find (
	input  logic [spra_pkg::MASK_W-1:0] mask,
	input  logic [spra_pkg::MASK_W-1:0] need,
	output spra_pkg::fit_t              fit
);
	import spra_pkg::*;

	logic [MASK_W-1:0] hit;

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			hit[i] = ((mask >> i) & need) == need;
		end
		fit.found = |hit;
		fit.start = '0;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (hit[i]) fit.start = OFS_W'(i);
		end
	end

endmodule

// ----- rtl/segment_page_run_allocator_core.sv -----
// Segment page-run allocator: walks the free-segment list held in one RAM
// Usage:
//   req (valid/ready) takes one word: req_type, run_pages, page_index.
//   rsp (valid/ready) returns one word per request: page_index_out, status.
//   One request is in work at a time; req.ready is high only when the block
//   is idle and its response register is empty.
//   A take walks the list, each hop a RAM read and then a fit check, for up to
//   MAX_HOPS hops; if no fit is found it maps a fresh segment, and each
//   neighbor link fix-up is a read and then a write back.
//   The registered RAM read data sets the per-hop cost.
//   A release updates the segment's mask, plus a read and write back of the old
//   head's link when the segment is relinked at the head; a release outside the
//   mapped segments answers the cycle after acceptance.
//   Reset empties the list and unmaps all segments at once; no clearing pass
//   is run, since a segment's RAM word is written when it is mapped.
//   When the receiver stalls, the response holds and no new request is taken.
module segment_page_run_allocator_core #(
	parameter int NUM_SEGMENTS = spra_pkg::NUM_SEGMENTS_DEF,
	parameter int MAX_HOPS     = spra_pkg::MAX_HOPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	spra_req_if.sink req,
	spra_rsp_if.source rsp
);
	import spra_pkg::*;

	localparam int SW = $clog2(NUM_SEGMENTS + 1);
	localparam int HW = $clog2(MAX_HOPS + 1);
	localparam int EW = MASK_W + 2 * SW + 1;
	localparam int PV = MASK_W;
	localparam int NX = MASK_W + SW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_P_RD = 3'd3;
	localparam logic [2:0] S_P_WR = 3'd4;
	localparam logic [2:0] S_N_RD = 3'd5;
	localparam logic [2:0] S_N_WR = 3'd6;

	logic [2:0]        st_q;
	logic              type_q;
	logic [MASK_W-1:0] need_q;
	logic              full_run_q;
	logic [MASK_W-1:0] relmask_q;
	logic [SW-1:0]     cur_q, head_q, mc_q;
	logic [HW-1:0]     hops_q;
	logic [SW-1:0]     fp_q, fpv_q, fn_q, fnv_q;
	logic              don_q;
	logic [PAGE_W-1:0] res_page_q;
	logic              res_stat_q;
	logic              ov_q;

	logic              we, re;
	logic [SW-1:0]     waddr, raddr;
	logic [EW-1:0]     wdata, rdata;

	logic              acc;
	logic [RUN_W-1:0]  npg;
	logic [10:0]       rseg;
	logic              rel_ok;
	fit_t              fit;
	logic [MASK_W-1:0] rmask, nmask, clr;
	logic [SW-1:0]     rprev, rnext, newseg;
	logic              ron;

	function automatic logic [PAGE_W-1:0] page_of(input logic [SW-1:0] s,
			input logic [OFS_W-1:0] start);
		logic [31:0] t;
		t = ((32'(s) - 32'd1) << OFS_W) | 32'(start);
		return t[PAGE_W-1:0];
	endfunction

	function automatic logic [EW-1:0] pack(input logic on, input logic [SW-1:0] nx,
			input logic [SW-1:0] pv, input logic [MASK_W-1:0] m);
		return {on, nx, pv, m};
	endfunction

	spra_ram #(.WIDTH(EW), .DEPTH(NUM_SEGMENTS + 1)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rmask = rdata[MASK_W-1:0];
	assign rprev = rdata[PV +: SW];
	assign rnext = rdata[NX +: SW];
	assign ron   = rdata[EW-1];

	spra_run_find u_find (
		.mask(rmask),
		.need(need_q),
		.fit (fit)
	);

	assign acc    = req.valid && req.ready;
	assign npg    = sat_pages(req.run_pages);
	assign rseg   = {1'b0, req.page_index[PAGE_W-1:OFS_W]} + 11'd1;
	assign rel_ok = (32'(rseg) <= NUM_SEGMENTS) && (32'(rseg) <= 32'(mc_q));
	assign newseg = mc_q + SW'(1);
	assign clr    = 32'((64'(need_q) << fit.start));
	assign nmask  = rmask & ~clr;

	assign req.ready          = (st_q == S_IDLE) && !ov_q;
	assign rsp.valid          = ov_q;
	assign rsp.page_index_out = res_page_q;
	assign rsp.status         = res_stat_q;

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = cur_q;
		raddr = cur_q;
		wdata = rdata;
		case (st_q)
			S_IDLE: begin
				raddr = SW'(rseg);
				re    = acc && req.req_type == REQ_RELEASE && rel_ok;
			end
			S_WALK: begin
				if (cur_q != '0 && hops_q != HW'(MAX_HOPS)) begin
					re = 1'b1;
				end else if (32'(mc_q) < NUM_SEGMENTS) begin
					we    = 1'b1;
					waddr = newseg;
					wdata = full_run_q ? pack(1'b0, head_q, '0, '0)
						: pack(1'b1, head_q, '0, ~need_q);
				end
			end
			S_CHK: begin
				if (type_q == REQ_TAKE) begin
					if (fit.found) begin
						we    = 1'b1;
						wdata = pack(ron && nmask != '0, rnext, rprev, nmask);
					end
				end else begin
					we    = 1'b1;
					wdata = ron ? pack(1'b1, rnext, rprev, rmask | relmask_q)
						: pack(1'b1, head_q, '0, rmask | relmask_q);
				end
			end
			S_P_RD: begin
				re    = 1'b1;
				raddr = fp_q;
			end
			S_P_WR: begin
				we    = 1'b1;
				waddr = fp_q;
				wdata = pack(ron, fpv_q, rprev, rmask);
			end
			S_N_RD: begin
				re    = 1'b1;
				raddr = fn_q;
			end
			S_N_WR: begin
				we    = 1'b1;
				waddr = fn_q;
				wdata = pack(ron, rnext, fnv_q, rmask);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			ov_q   <= 1'b0;
			head_q <= '0;
			mc_q   <= '0;
			hops_q <= '0;
			don_q  <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) ov_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						type_q     <= req.req_type;
						need_q     <= run_bits(npg);
						full_run_q <= npg == RUN_W'(PAGES_PER_SEG);
						relmask_q  <= 32'((64'(run_bits(npg)) << req.page_index[OFS_W-1:0]));
						hops_q     <= '0;
						don_q      <= 1'b0;
						res_stat_q <= STAT_OK;
						res_page_q <= req.page_index;
						if (req.req_type == REQ_TAKE) begin
							cur_q <= head_q;
							st_q  <= S_WALK;
						end else if (rel_ok) begin
							cur_q <= SW'(rseg);
							st_q  <= S_CHK;
						end else begin
							ov_q <= 1'b1;
						end
					end
				end
				S_WALK: begin
					if (cur_q != '0 && hops_q != HW'(MAX_HOPS)) begin
						st_q <= S_CHK;
					end else if (32'(mc_q) < NUM_SEGMENTS) begin
						mc_q       <= newseg;
						res_page_q <= page_of(newseg, '0);
						if (!full_run_q) begin
							head_q <= newseg;
							fn_q   <= head_q;
							fnv_q  <= newseg;
						end
						if (!full_run_q && head_q != '0) begin
							st_q <= S_N_RD;
						end else begin
							st_q <= S_IDLE;
							ov_q <= 1'b1;
						end
					end else begin
						res_page_q <= '0;
						res_stat_q <= STAT_EXHAUSTED;
						st_q       <= S_IDLE;
						ov_q       <= 1'b1;
					end
				end
				S_CHK: begin
					if (type_q == REQ_TAKE) begin
						if (fit.found) begin
							res_page_q <= page_of(cur_q, fit.start);
							if (nmask == '0) begin
								fp_q  <= rprev;
								fpv_q <= rnext;
								fn_q  <= rnext;
								fnv_q <= rprev;
								don_q <= rnext != '0;
								if (rprev == '0) head_q <= rnext;
								if (rprev != '0) begin
									st_q <= S_P_RD;
								end else if (rnext != '0) begin
									st_q <= S_N_RD;
								end else begin
									st_q <= S_IDLE;
									ov_q <= 1'b1;
								end
							end else begin
								st_q <= S_IDLE;
								ov_q <= 1'b1;
							end
						end else begin
							cur_q  <= rnext;
							hops_q <= hops_q + HW'(1);
							st_q   <= S_WALK;
						end
					end else if (!ron) begin
						head_q <= cur_q;
						fn_q   <= head_q;
						fnv_q  <= cur_q;
						if (head_q != '0) begin
							st_q <= S_N_RD;
						end else begin
							st_q <= S_IDLE;
							ov_q <= 1'b1;
						end
					end else begin
						st_q <= S_IDLE;
						ov_q <= 1'b1;
					end
				end
				S_P_RD: st_q <= S_P_WR;
				S_P_WR: begin
					if (don_q) begin
						st_q <= S_N_RD;
					end else begin
						st_q <= S_IDLE;
						ov_q <= 1'b1;
					end
				end
				S_N_RD: st_q <= S_N_WR;
				S_N_WR: begin
					st_q <= S_IDLE;
					ov_q <= 1'b1;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/spra_checker.sv -----
// Port-level checks of the allocator, bound to the top level
module spra_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        req_type,
	input logic [spra_pkg::PAGE_W-1:0] page_index,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [spra_pkg::PAGE_W-1:0] page_index_out,
	input logic                        status
);
	import spra_pkg::*;
	`include "segment_page_run_allocator_core_assert.svh"

	logic              rel_q;
	logic [PAGE_W-1:0] pidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			rel_q  <= req_type == REQ_RELEASE;
			pidx_q <= page_index;
		end
	end

	`SPRA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`SPRA_ASSERT_IMP(a_one_in_flight, req_valid && req_ready, !rsp_valid)
	`SPRA_ASSERT_IMP(a_release_echo, rsp_valid && rel_q,
		status == STAT_OK && page_index_out == pidx_q)
	`SPRA_ASSERT_IMP(a_exhaust_zero, rsp_valid && status == STAT_EXHAUSTED,
		page_index_out == '0 && !rel_q)

endmodule

bind segment_page_run_allocator_core spra_checker u_spra_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.page_index    (req.page_index),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.page_index_out(rsp.page_index_out),
	.status        (rsp.status)
);
